// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define TSF_ASSERT(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error(msg);

// Check that a condition never holds outside of reset.
`define TSF_ASSERT_NEVER(label, clk, rstn, cond, msg) \
	`TSF_ASSERT(label, clk, rstn, !(cond), msg)

`endif

// ----- sv/tsf_pkg.sv -----
// ----------------------------------------------------------------------------
// Tone slant filter package
// Field widths, register indexes and shared types of the tilt filter.
// ----------------------------------------------------------------------------
package tsf_pkg;

	// Field widths fixed by the register map and the number formats
	localparam int TAP_W      = 7;
	localparam int COEF_FRAC  = 17;
	localparam int COEF_W     = 18;
	localparam int SLANT_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLANT     = 2'd1;

	typedef logic [COEF_W-1:0] coef_t;

	// Per-step strobes from the sequencer to each channel lane
	typedef struct packed {
		logic load;     // take a new sample, clear the accumulator
		logic mac_en;   // memory data valid this cycle, multiply
		logic tap_ok;   // history row was written, else treat as zero
		logic diff_en;  // form x - 2*lowpass
		logic prod_en;  // multiply by slant
		logic sum_en;   // round and combine the partial products
	} lane_ctrl_t;

endpackage

// ----- sv/tsf_if.sv -----
// ----------------------------------------------------------------------------
// Tone slant filter channels
// Valid/ready channels for input frames and filtered result frames.
// ----------------------------------------------------------------------------
interface tsf_in_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] left_sample;
	logic signed [SAMPLE_WIDTH-1:0] right_sample;
	logic                           end_of_buffer;

	modport source (output valid, left_sample, right_sample, end_of_buffer, input ready);
	modport sink (input valid, left_sample, right_sample, end_of_buffer, output ready);
endinterface

interface tsf_out_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] left_result;
	logic signed [SAMPLE_WIDTH-1:0] right_result;
	logic                           end_flag;

	modport source (output valid, left_result, right_result, end_flag, input ready);
	modport sink (input valid, left_result, right_result, end_flag, output ready);
endinterface

// ----- sv/tsf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/tsf_coef_build.sv -----
// ----------------------------------------------------------------------------
// Triangular window coefficient builder
// Fills the coefficient memory with round((N-k)/N^2) in Q1.17, one entry
// per pass of a restoring divider that retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tsf_coef_build #(
	parameter int MAX_TAPS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tsf_pkg::TAP_W-1:0]   n_taps,
	output logic                        busy,
	output logic                        coef_we,
	output logic [$clog2(MAX_TAPS)-1:0] coef_waddr,
	output tsf_pkg::coef_t              coef_wdata
);

	localparam int AW    = $clog2(MAX_TAPS);
	localparam int CW    = (AW > tsf_pkg::TAP_W) ? AW : tsf_pkg::TAP_W;
	localparam int SQ_W  = 2 * tsf_pkg::TAP_W;
	localparam int RW    = SQ_W + 1;
	localparam int NUM_W = tsf_pkg::TAP_W + tsf_pkg::COEF_FRAC;
	localparam int IT_W  = $clog2(tsf_pkg::COEF_W);

	localparam logic [1:0] BS_IDLE  = 2'd0;
	localparam logic [1:0] BS_SETUP = 2'd1;
	localparam logic [1:0] BS_ITER  = 2'd2;
	localparam logic [1:0] BS_WRITE = 2'd3;

	logic [1:0]                state_q;
	logic [tsf_pkg::TAP_W-1:0] n_q;
	logic [SQ_W-1:0]           sq_q;
	logic [AW-1:0]             k_q;
	logic [IT_W-1:0]           it_q;
	logic [RW-1:0]             r_q;
	tsf_pkg::coef_t            q_q;

	logic [NUM_W-1:0] num;
	logic [RW-1:0]    shifted;
	logic             ge;
	logic             last_k;

	// Numerator (N-k)*2^17 + N^2/2 and one divider step
	always_comb begin
		num     = {n_q - tsf_pkg::TAP_W'(k_q), {tsf_pkg::COEF_FRAC{1'b0}}}
			+ NUM_W'(sq_q >> 1);
		shifted = {r_q[RW-2:0], q_q[tsf_pkg::COEF_W-1]};
		ge      = (shifted >= RW'(sq_q));
		last_k  = (CW'(k_q) == CW'(n_q - 1'b1));
	end

	// Sequence entries and divider steps; a new start restarts the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			n_q     <= '0;
			sq_q    <= '0;
			k_q     <= '0;
			it_q    <= '0;
			r_q     <= '0;
			q_q     <= '0;
		end else if (start) begin
			n_q     <= n_taps;
			sq_q    <= n_taps * n_taps;
			k_q     <= '0;
			state_q <= BS_SETUP;
		end else begin
			case (state_q)
				BS_IDLE: begin
				end
				BS_SETUP: begin
					// quotient fits in COEF_W bits, so the upper part starts below N^2
					r_q     <= RW'(num >> tsf_pkg::COEF_W);
					q_q     <= num[tsf_pkg::COEF_W-1:0];
					it_q    <= '0;
					state_q <= BS_ITER;
				end
				BS_ITER: begin
					r_q  <= ge ? (shifted - RW'(sq_q)) : shifted;
					q_q  <= {q_q[tsf_pkg::COEF_W-2:0], ge};
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(tsf_pkg::COEF_W - 1)) begin
						state_q <= BS_WRITE;
					end
				end
				BS_WRITE: begin
					if (last_k) begin
						state_q <= BS_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= BS_SETUP;
					end
				end
				default: state_q <= BS_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != BS_IDLE);
	assign coef_we    = (state_q == BS_WRITE);
	assign coef_waddr = k_q;
	assign coef_wdata = q_q;

endmodule

// ----- sv/tsf_lane.sv -----
// ----------------------------------------------------------------------------
// Tilt filter channel lane
// Multiply-accumulate over the history taps, then x + (x - 2*lowpass)*slant
// with round half up and saturation to the sample width.
// ----------------------------------------------------------------------------
module tsf_lane #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tsf_pkg::lane_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	input  logic signed [SAMPLE_WIDTH-1:0]      hist,
	input  tsf_pkg::coef_t                      coef,
	input  logic signed [tsf_pkg::SLANT_W-1:0]  slant,
	output logic signed [SAMPLE_WIDTH-1:0]      result
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int SLW   = tsf_pkg::SLANT_W;
	localparam int PW    = SW + tsf_pkg::COEF_W + 1;
	localparam int ACC_W = PW + tsf_pkg::TAP_W;
	localparam int D_W   = ACC_W + 2;
	localparam int HI_W  = D_W - SLW;
	localparam int A_W   = HI_W + SLW;
	localparam int B_W   = 2 * SLW + 2;
	localparam int S_W   = A_W + 1;
	localparam int T_W   = S_W - SLW;
	localparam int Y_W   = T_W + 1;

	localparam logic signed [B_W-1:0] RND  = B_W'(1) << (2 * SLW - 1);
	localparam logic signed [Y_W-1:0] YMAX = $signed({{(Y_W-SW+1){1'b0}}, {(SW-1){1'b1}}});
	localparam logic signed [Y_W-1:0] YMIN = $signed({{(Y_W-SW+1){1'b1}}, {(SW-1){1'b0}}});

	logic signed [SW-1:0]    x_q;
	logic signed [PW-1:0]    prod_s2;
	logic                    pv_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [D_W-1:0]   d_q;
	logic signed [A_W-1:0]   a_q;
	logic signed [B_W-1:0]   b_q;
	logic signed [T_W-1:0]   t_q;

	logic signed [SW-1:0]    hist_m;
	logic signed [HI_W-1:0]  d_hi;
	logic signed [SLW:0]     d_lo;
	logic signed [S_W-1:0]   b_ext;
	logic signed [S_W-1:0]   ssum;
	logic signed [T_W-1:0]   t_d;
	logic signed [Y_W-1:0]   ysum;

	// Drop taps that were never written
	assign hist_m = ctrl.tap_ok ? hist : '0;

	// Split the difference into a high part and an unsigned low half-word
	assign d_hi = $signed(d_q[D_W-1:SLW]);
	assign d_lo = $signed({1'b0, d_q[SLW-1:0]});

	// Combine partial products, then drop the rounding fraction
	always_comb begin
		b_ext = S_W'(b_q);
		ssum  = S_W'(a_q) + (b_ext >>> SLW);
		t_d   = T_W'(ssum >>> SLW);
	end

	// Add the tilt term and clamp
	always_comb begin
		ysum = Y_W'(x_q) + Y_W'(t_q);
		if (ysum > YMAX) begin
			result = YMAX[SW-1:0];
		end else if (ysum < YMIN) begin
			result = YMIN[SW-1:0];
		end else begin
			result = ysum[SW-1:0];
		end
	end

	// Track which product stage holds a tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s2 <= 1'b0;
		end else begin
			pv_s2 <= ctrl.mac_en;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q   <= sample;
			acc_q <= '0;
		end else if (pv_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (ctrl.mac_en) begin
			prod_s2 <= hist_m * $signed({1'b0, coef});
		end
		if (ctrl.diff_en) begin
			d_q <= (D_W'(x_q) <<< tsf_pkg::COEF_FRAC) - (D_W'(acc_q) <<< 1);
		end
		if (ctrl.prod_en) begin
			a_q <= d_hi * slant;
			b_q <= d_lo * slant + RND;
		end
		if (ctrl.sum_en) begin
			t_q <= t_d;
		end
	end

endmodule

// ----- sv/tone_slant_fir_filter_unit.sv -----
// ----------------------------------------------------------------------------
// Tone slant FIR filter unit
// Stereo tilt filter built around a history memory and a coefficient memory.
// ----------------------------------------------------------------------------
// Each input word is one left/right frame. The frame is written into a
// history memory (both channels in one row) and the lowpass sum runs one tap
// per cycle, bounded by the single read port of that memory, with both
// channels multiplied side by side. The tap count is clamped to
// 1..MAX_TAPS, and the next frame is taken only after the result of the
// last one is loaded into the output register. Writing tap_count rebuilds
// the coefficient memory with a bit-serial divider; the same rebuild runs
// for one tap after reset. Input is held off meanwhile. History rows that
// were never written read as zero through a fill count, so there is no
// clearing pass.
// ----------------------------------------------------------------------------
module tone_slant_fir_filter_unit #(
	parameter int MAX_TAPS     = 128,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tsf_in_if.sink                           in_frame,
	tsf_out_if.source                        out_frame,
	input  logic                             cfg_we,
	input  logic [tsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tsf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int AW    = $clog2(MAX_TAPS);
	localparam int FW    = $clog2(MAX_TAPS + 1);
	localparam int TAP_W = tsf_pkg::TAP_W;
	localparam int CW    = (AW > TAP_W) ? AW : TAP_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DIFF  = 3'd3;
	localparam logic [2:0] ST_PROD  = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]                          state_q;
	logic [AW-1:0]                       k_q;
	logic [AW-1:0]                       rd_ptr_q;
	logic [AW-1:0]                       pos_q;
	logic [FW-1:0]                       fill_q;
	logic                                iss_s1;
	logic                                iss_s2;
	logic                                tap_ok_s1;
	logic [TAP_W-1:0]                    n_q;
	logic signed [tsf_pkg::SLANT_W-1:0]  slant_q;
	logic                                build_go_q;
	logic                                out_valid_q;
	logic                                eob_q;
	logic signed [SW-1:0]                left_q;
	logic signed [SW-1:0]                right_q;
	logic                                end_q;

	logic                                in_rdy;
	logic                                accept;
	logic                                out_load;
	logic                                last_tap;
	logic                                tap_ok;
	logic [TAP_W-1:0]                    tap_raw;
	logic [TAP_W-1:0]                    n_clamp;
	logic                                build_busy;
	logic                                coef_we;
	logic [AW-1:0]                       coef_waddr;
	tsf_pkg::coef_t                      coef_wdata;
	tsf_pkg::coef_t                      coef_rdata;
	logic [2*SW-1:0]                     hist_rdata;
	tsf_pkg::lane_ctrl_t                 lane_ctrl;
	logic signed [SW-1:0]                y_left;
	logic signed [SW-1:0]                y_right;

	// Handshake
	assign in_rdy         = (state_q == ST_IDLE) && !build_busy && !build_go_q && !cfg_we;
	assign in_frame.ready = in_rdy;
	assign accept         = in_frame.valid && in_rdy;
	assign out_load       = (state_q == ST_OUT) && (!out_valid_q || out_frame.ready);

	// Tap sequencing
	assign last_tap = (CW'(k_q) == CW'(n_q - 1'b1));
	assign tap_ok   = (FW'(k_q) < fill_q);

	// Clamp the tap count to 1..MAX_TAPS
	always_comb begin
		tap_raw = cfg_data[TAP_W-1:0];
		if (tap_raw == '0) begin
			n_clamp = TAP_W'(1);
		end else if (int'(tap_raw) > MAX_TAPS) begin
			n_clamp = TAP_W'(MAX_TAPS);
		end else begin
			n_clamp = tap_raw;
		end
	end

	// Lane strobes
	always_comb begin
		lane_ctrl         = '0;
		lane_ctrl.load    = accept;
		lane_ctrl.mac_en  = iss_s1;
		lane_ctrl.tap_ok  = tap_ok_s1;
		lane_ctrl.diff_en = (state_q == ST_DIFF);
		lane_ctrl.prod_en = (state_q == ST_PROD);
		lane_ctrl.sum_en  = (state_q == ST_SUM);
	end

	// Control: configuration, frame sequencer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			rd_ptr_q    <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			iss_s1      <= 1'b0;
			iss_s2      <= 1'b0;
			tap_ok_s1   <= 1'b0;
			n_q         <= TAP_W'(1);
			slant_q     <= '0;
			build_go_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			iss_s1     <= 1'b0;
			iss_s2     <= iss_s1;
			build_go_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					tsf_pkg::REG_TAP_COUNT: begin
						n_q        <= n_clamp;
						build_go_q <= 1'b1;
					end
					tsf_pkg::REG_SLANT: begin
						slant_q <= $signed(cfg_data[tsf_pkg::SLANT_W-1:0]);
					end
					default: begin
					end
				endcase
			end

			if (out_frame.valid && out_frame.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_ptr_q <= pos_q;
						k_q      <= '0;
						pos_q    <= (pos_q == AW'(MAX_TAPS - 1)) ? '0 : pos_q + 1'b1;
						if (fill_q != FW'(MAX_TAPS)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// issue one history row and one coefficient per cycle
					iss_s1    <= 1'b1;
					tap_ok_s1 <= tap_ok;
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q      <= k_q + 1'b1;
						rd_ptr_q <= (rd_ptr_q == '0) ? AW'(MAX_TAPS - 1) : rd_ptr_q - 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!iss_s1 && !iss_s2) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_PROD;
				ST_PROD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the end marker and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			eob_q <= in_frame.end_of_buffer;
		end
		if (out_load) begin
			left_q  <= y_left;
			right_q <= y_right;
			end_q   <= eob_q;
		end
	end

	assign out_frame.valid        = out_valid_q;
	assign out_frame.left_result  = left_q;
	assign out_frame.right_result = right_q;
	assign out_frame.end_flag     = end_q;

	// History memory, right channel in the upper half of each row
	tsf_ram #(
		.WIDTH (2 * SW),
		.DEPTH (MAX_TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (pos_q),
		.wdata ({in_frame.right_sample, in_frame.left_sample}),
		.raddr (rd_ptr_q),
		.rdata (hist_rdata)
	);

	// Coefficient memory
	tsf_ram #(
		.WIDTH (tsf_pkg::COEF_W),
		.DEPTH (MAX_TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (k_q),
		.rdata (coef_rdata)
	);

	tsf_coef_build #(
		.MAX_TAPS (MAX_TAPS)
	) u_coef_build (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (build_go_q),
		.n_taps     (n_q),
		.busy       (build_busy),
		.coef_we    (coef_we),
		.coef_waddr (coef_waddr),
		.coef_wdata (coef_wdata)
	);

	tsf_lane #(
		.SAMPLE_WIDTH (SW)
	) u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.sample (in_frame.left_sample),
		.hist   ($signed(hist_rdata[SW-1:0])),
		.coef   (coef_rdata),
		.slant  (slant_q),
		.result (y_left)
	);

	tsf_lane #(
		.SAMPLE_WIDTH (SW)
	) u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.sample (in_frame.right_sample),
		.hist   ($signed(hist_rdata[2*SW-1:SW])),
		.coef   (coef_rdata),
		.slant  (slant_q),
		.result (y_right)
	);

endmodule

// ----- sv/tsf_checker.sv -----
// ----------------------------------------------------------------------------
// Tone slant filter checker
// Port-level assertions on frame sequencing and configuration stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsf_checker #(
	parameter int SAMPLE_WIDTH = 24
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [SAMPLE_WIDTH-1:0]        out_left,
	input logic [SAMPLE_WIDTH-1:0]        out_right,
	input logic                           out_end,
	input logic                           cfg_we,
	input logic [tsf_pkg::CFG_IDX_W-1:0]  cfg_index
);

	// Hold a stalled result word
	`TSF_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_left) && $stable(out_right) && $stable(out_end)), "result word changed while stalled")

	// Take one frame at a time
	`TSF_ASSERT(a_one_frame, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "second frame taken while one is in flight")

	// Stall input while the coefficients are rebuilt
	`TSF_ASSERT(a_rebuild_stall, clk, arst_n, (cfg_we && (cfg_index == tsf_pkg::REG_TAP_COUNT)) |=> !in_ready, "frame taken during coefficient rebuild")

	// No result can follow a frame before the tap sum could finish
	`TSF_ASSERT(a_no_early_result, clk, arst_n, (in_valid && in_ready) |=> (!$rose(out_valid) ##1 !$rose(out_valid)), "result shown before the tap sum could finish")

	// Never take a frame during a register write
	`TSF_ASSERT_NEVER(a_no_accept_on_cfg, clk, arst_n, in_valid && in_ready && cfg_we, "frame taken in the cycle of a register write")

endmodule

bind tone_slant_fir_filter_unit tsf_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_frame.valid),
	.in_ready  (in_frame.ready),
	.out_valid (out_frame.valid),
	.out_ready (out_frame.ready),
	.out_left  (out_frame.left_result),
	.out_right (out_frame.right_result),
	.out_end   (out_frame.end_flag),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index)
);
